@@ rtl/lpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HDR_LEN_W  = 4;
  localparam int unsigned TOT_LEN_W  = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MAX_HEADER_BYTES_DEF    = 8;
  localparam int unsigned LENGTH_FIELD_OFFSET_DEF = 0;
  localparam int unsigned HDR_LEN_MIN             = 2;

  // receive buffer less a safety margin
  localparam int unsigned RX_BUF_BYTES  = 30000;
  localparam int unsigned RX_BUF_MARGIN = 1000;

  localparam logic [HDR_LEN_W-1:0] HEADER_LEN_RST    = HDR_LEN_W'(8);
  localparam logic [TOT_LEN_W-1:0] MAX_TOTAL_LEN_RST =
    TOT_LEN_W'(RX_BUF_BYTES - RX_BUF_MARGIN);

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL_LEN = CFG_IDX_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    FS_PACKET = 2'd0,
    FS_SHORT  = 2'd1,
    FS_LONG   = 2'd2
  } frame_status_t;

  typedef enum logic [2:0] {
    S_HDR   = 3'b001,
    S_BURST = 3'b010,
    S_BODY  = 3'b100
  } lpd_state_t;

  typedef struct packed {
    logic take_hdr;
    logic take_body;
    logic emit_burst;
  } lpd_cmd_t;

  typedef struct packed {
    logic hdr_complete;
    logic len_ok;
    logic burst_last;
    logic body_none;
    logic body_last;
    logic out_free;
  } lpd_sts_t;

endpackage

`default_nettype wire

@@ rtl/lpd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lpd_in_if import lpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpd_out_if import lpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                first_of_packet;
  logic                last_of_packet;
  logic [STATUS_W-1:0] frame_status;

  modport source (output valid, output out_byte, output first_of_packet,
                  output last_of_packet, output frame_status, input ready);
  modport sink (input valid, input out_byte, input first_of_packet,
                input last_of_packet, input frame_status, output ready);
endinterface

`default_nettype wire

@@ rtl/lpd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpd_ctrl import lpd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lpd_sts_t sts,
  output lpd_cmd_t      cmd
);

  lpd_state_t state_r, state_nxt;
  logic       take;

  always_comb begin
    in_ready = 1'b0;
    unique case (state_r)
      S_HDR:   in_ready = !sts.hdr_complete || sts.out_free;
      S_BODY:  in_ready = sts.out_free;
      S_BURST: in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  assign take           = in_valid && in_ready;
  assign cmd.take_hdr   = (state_r == S_HDR) && take;
  assign cmd.take_body  = (state_r == S_BODY) && take;
  assign cmd.emit_burst = (state_r == S_BURST) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_HDR: begin
        if (cmd.take_hdr && sts.hdr_complete && sts.len_ok) state_nxt = S_BURST;
      end
      S_BURST: begin
        if (cmd.emit_burst && sts.burst_last) begin
          state_nxt = sts.body_none ? S_HDR : S_BODY;
        end
      end
      S_BODY: begin
        if (cmd.take_body && sts.body_last) state_nxt = S_HDR;
      end
      default: state_nxt = S_HDR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HDR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lpd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpd_dp import lpd_pkg::*; #(
  parameter int unsigned MAX_HEADER_BYTES    = MAX_HEADER_BYTES_DEF,
  parameter int unsigned LENGTH_FIELD_OFFSET = LENGTH_FIELD_OFFSET_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [BYTE_W-1:0]     in_byte,
  input  wire lpd_cmd_t              cmd,
  output lpd_sts_t                   sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [BYTE_W-1:0]          out_byte,
  output logic                       out_first,
  output logic                       out_last,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int unsigned CNT_W = $clog2(MAX_HEADER_BYTES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_HEADER_BYTES);

  logic [HDR_LEN_W-1:0] header_len_r;
  logic [TOT_LEN_W-1:0] max_total_len_r;

  logic [BYTE_W-1:0]    store_r [MAX_HEADER_BYTES];
  logic [CNT_W-1:0]     hdr_count_r;
  logic [IDX_W-1:0]     burst_idx_r;
  logic [TOT_LEN_W-1:0] body_rem_r;

  logic                 out_valid_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic                 out_first_r;
  logic                 out_last_r;
  frame_status_t        out_status_r;

  logic [CNT_W-1:0]     hl;
  logic [BYTE_W-1:0]    len_hi;
  logic [BYTE_W-1:0]    len_lo;
  logic [TOT_LEN_W-1:0] len;
  logic                 too_short;
  logic                 too_long;
  logic                 load_reject;
  logic                 out_load;

  // effective header length, clamped to the supported range
  always_comb begin
    if (int'(header_len_r) > int'(MAX_HEADER_BYTES)) begin
      hl = CNT_W'(MAX_HEADER_BYTES);
    end else if (int'(header_len_r) < int'(HDR_LEN_MIN)) begin
      hl = CNT_W'(HDR_LEN_MIN);
    end else begin
      hl = CNT_W'(header_len_r);
    end
  end

  // length bytes, with the byte being taken now bypassed in
  always_comb begin
    len_hi = '0;
    len_lo = '0;
    if ((LENGTH_FIELD_OFFSET < MAX_HEADER_BYTES) &&
        (CNT_W'(LENGTH_FIELD_OFFSET) < hl)) begin
      len_hi = (hdr_count_r == CNT_W'(LENGTH_FIELD_OFFSET)) ? in_byte :
               store_r[IDX_W'(LENGTH_FIELD_OFFSET)];
    end
    if ((LENGTH_FIELD_OFFSET + 1 < MAX_HEADER_BYTES) &&
        (CNT_W'(LENGTH_FIELD_OFFSET + 1) < hl)) begin
      len_lo = (hdr_count_r == CNT_W'(LENGTH_FIELD_OFFSET + 1)) ? in_byte :
               store_r[IDX_W'(LENGTH_FIELD_OFFSET + 1)];
    end
  end

  assign len       = {len_hi, len_lo};
  assign too_short = len < TOT_LEN_W'(hl);
  assign too_long  = len > max_total_len_r;

  assign sts.hdr_complete = (hdr_count_r + CNT_W'(1)) >= hl;
  assign sts.len_ok       = !too_short && !too_long;
  assign sts.burst_last   = (CNT_W'(burst_idx_r) + CNT_W'(1)) == hl;
  assign sts.body_none    = body_rem_r == '0;
  assign sts.body_last    = body_rem_r <= TOT_LEN_W'(1);
  assign sts.out_free     = !out_valid_r || out_ready;

  assign load_reject = cmd.take_hdr && sts.hdr_complete && !sts.len_ok;
  assign out_load    = load_reject || cmd.emit_burst || cmd.take_body;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_len_r    <= HEADER_LEN_RST;
      max_total_len_r <= MAX_TOTAL_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_LEN:    header_len_r    <= cfg_data[HDR_LEN_W-1:0];
        CFG_MAX_TOTAL_LEN: max_total_len_r <= cfg_data[TOT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hdr) begin
      store_r[hdr_count_r[IDX_W-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_count_r <= '0;
      burst_idx_r <= '0;
      body_rem_r  <= '0;
    end else begin
      if (cmd.take_hdr) begin
        if (sts.hdr_complete) begin
          hdr_count_r <= '0;
          if (sts.len_ok) begin
            burst_idx_r <= '0;
            body_rem_r  <= len - TOT_LEN_W'(hl);
          end
        end else begin
          hdr_count_r <= hdr_count_r + CNT_W'(1);
        end
      end
      if (cmd.emit_burst) begin
        burst_idx_r <= burst_idx_r + IDX_W'(1);
      end
      if (cmd.take_body) begin
        body_rem_r <= sts.body_last ? '0 : body_rem_r - TOT_LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_reject) begin
      out_byte_r   <= '0;
      out_first_r  <= 1'b0;
      out_last_r   <= 1'b0;
      out_status_r <= too_short ? FS_SHORT : FS_LONG;
    end else if (cmd.emit_burst) begin
      out_byte_r   <= store_r[burst_idx_r];
      out_first_r  <= burst_idx_r == '0;
      out_last_r   <= sts.burst_last && sts.body_none;
      out_status_r <= FS_PACKET;
    end else if (cmd.take_body) begin
      out_byte_r   <= in_byte;
      out_first_r  <= 1'b0;
      out_last_r   <= sts.body_last;
      out_status_r <= FS_PACKET;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_first  = out_first_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

@@ rtl/length_prefixed_packet_deframer.sv @@
// Length-prefixed packet deframer.
// in_ch carries received bytes (rx_byte) with a valid/ready handshake; out_ch
// carries packet bytes with first/last marks and a frame status. cfg_we,
// cfg_index and cfg_data write header_len (index 0) and max_total_len (1).
// Header bytes are taken one per cycle and produce nothing until the header
// is complete. A bad length gives one rejection item in the next cycle. A
// good length gives the stored header as a burst of header_len items
// (clamped to HDR_LEN_MIN..MAX_HEADER_BYTES), one per cycle while the sink
// keeps up; the controller first moves to S_BURST and each item then
// passes through the output register. The input is held off during the
// burst since the burst is read from the header store. Body bytes then pass
// one per cycle while the sink keeps up, through the output register.
// Sustained rate: one byte per cycle in the body when the sink keeps up.
// A stalled sink holds the output register; one byte may be taken while a
// finished item waits only if it is a non-final header byte, otherwise
// in_ch.ready drops until the output register drains.
// Reset (synchronous, rst_n low) restores header_len 8 and max_total_len
// 29000, clears the output and restarts header collection.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_packet_deframer import lpd_pkg::*; #(
  parameter int unsigned MAX_HEADER_BYTES    = MAX_HEADER_BYTES_DEF,
  parameter int unsigned LENGTH_FIELD_OFFSET = LENGTH_FIELD_OFFSET_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  lpd_in_if.sink                     in_ch,
  lpd_out_if.source                  out_ch
);

  lpd_cmd_t cmd;
  lpd_sts_t sts;

  lpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpd_dp #(
    .MAX_HEADER_BYTES    (MAX_HEADER_BYTES),
    .LENGTH_FIELD_OFFSET (LENGTH_FIELD_OFFSET)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_byte    (in_ch.rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .out_first  (out_ch.first_of_packet),
    .out_last   (out_ch.last_of_packet),
    .out_status (out_ch.frame_status)
  );

endmodule

`default_nettype wire
